// ===== hdl/circular_double_ended_queue_assert.svh =====
// Assertion macros used by the deque controller.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CDQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CDQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cdq_pkg.sv =====
// Types, constants and index helpers for the circular deque.
package cdq_pkg;

  localparam int DEPTH  = 8;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  typedef enum logic [2:0] {
    CMD_PUSH_REAR  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_LIST       = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_LRD,
    S_LDAT
  } state_e;

  // Result load request from the controller to the output register.
  typedef struct packed {
    logic    load;
    status_e status;
    logic    from_mem;
    logic    last;
  } res_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : IDX_W'(i + 1'b1);
  endfunction

  function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] i);
    return (i == '0) ? LAST_IDX : IDX_W'(i - 1'b1);
  endfunction

endpackage

// ===== hdl/cdq_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with a registered read port.
module cdq_ram #(
  parameter int DataWidth = 32,
  parameter int Depth     = 8,
  parameter int AddrWidth = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [DataWidth-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [DataWidth-1:0] rdata_o
);

  logic [DataWidth-1:0] mem_q [Depth];
  logic [DataWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/cdq_ctrl.sv =====
// Deque controller: indices, occupancy, command sequencing and list walk.
`include "circular_double_ended_queue_assert.svh"

module cdq_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [2:0]                 command_i,
  input  logic [cdq_pkg::DATA_W-1:0] push_value_i,
  input  logic                       out_free_i,
  output cdq_pkg::res_t              res_o,
  output logic                       we_o,
  output logic [cdq_pkg::IDX_W-1:0]  waddr_o,
  output logic [cdq_pkg::DATA_W-1:0] wdata_o,
  output logic                       re_o,
  output logic [cdq_pkg::IDX_W-1:0]  raddr_o
);

  cdq_pkg::state_e state_q, state_d;
  logic [cdq_pkg::IDX_W-1:0] head_q, head_d;
  logic [cdq_pkg::IDX_W-1:0] tail_q, tail_d;
  logic [cdq_pkg::IDX_W-1:0] ptr_q, ptr_d;
  logic [cdq_pkg::CNT_W-1:0] occ_q, occ_d;
  logic [cdq_pkg::CNT_W-1:0] n_q, n_d;
  logic                      accept;
  logic                      list_last;

  assign in_ready_o = (state_q == cdq_pkg::S_IDLE) && out_free_i;
  assign accept     = in_valid_i && in_ready_o;
  assign wdata_o    = push_value_i;
  assign list_last  = (cdq_pkg::CNT_W'(n_q + 1'b1) == occ_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cdq_pkg::S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      occ_q   <= '0;
      ptr_q   <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      occ_q   <= occ_d;
      ptr_q   <= ptr_d;
      n_q     <= n_d;
    end
  end

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    occ_d   = occ_q;
    ptr_d   = ptr_q;
    n_d     = n_q;
    we_o    = 1'b0;
    waddr_o = '0;
    re_o    = 1'b0;
    raddr_o = '0;
    res_o   = '0;

    case (state_q)
      cdq_pkg::S_IDLE: begin
        if (accept) begin
          case (cdq_pkg::cmd_e'(command_i))
            cdq_pkg::CMD_PUSH_REAR, cdq_pkg::CMD_PUSH_FRONT: begin
              res_o.load = 1'b1;
              res_o.last = 1'b1;
              if (occ_q == cdq_pkg::DEPTH_C) begin
                res_o.status = cdq_pkg::ST_FULL;
              end else begin
                res_o.status = cdq_pkg::ST_OK;
                we_o  = 1'b1;
                occ_d = cdq_pkg::CNT_W'(occ_q + 1'b1);
                if (occ_q == '0) begin
                  head_d  = '0;
                  tail_d  = '0;
                  waddr_o = '0;
                end else if (cdq_pkg::cmd_e'(command_i) == cdq_pkg::CMD_PUSH_REAR) begin
                  tail_d  = cdq_pkg::next_idx(tail_q);
                  waddr_o = tail_d;
                end else begin
                  head_d  = cdq_pkg::prev_idx(head_q);
                  waddr_o = head_d;
                end
              end
            end
            cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_REAR: begin
              if (occ_q == '0) begin
                res_o.load   = 1'b1;
                res_o.last   = 1'b1;
                res_o.status = cdq_pkg::ST_EMPTY;
              end else begin
                re_o    = 1'b1;
                occ_d   = cdq_pkg::CNT_W'(occ_q - 1'b1);
                state_d = cdq_pkg::S_POP;
                if (cdq_pkg::cmd_e'(command_i) == cdq_pkg::CMD_POP_FRONT) begin
                  raddr_o = head_q;
                  head_d  = cdq_pkg::next_idx(head_q);
                end else begin
                  raddr_o = tail_q;
                  tail_d  = cdq_pkg::prev_idx(tail_q);
                end
                if (occ_q == cdq_pkg::CNT_W'(1)) begin
                  head_d = '0;
                  tail_d = '0;
                end
              end
            end
            cdq_pkg::CMD_LIST: begin
              if (occ_q == '0) begin
                res_o.load   = 1'b1;
                res_o.last   = 1'b1;
                res_o.status = cdq_pkg::ST_EMPTY;
              end else begin
                ptr_d   = head_q;
                n_d     = '0;
                state_d = cdq_pkg::S_LRD;
              end
            end
            default: ;
          endcase
        end
      end
      cdq_pkg::S_POP: begin
        res_o.load     = 1'b1;
        res_o.status   = cdq_pkg::ST_OK;
        res_o.from_mem = 1'b1;
        res_o.last     = 1'b1;
        state_d        = cdq_pkg::S_IDLE;
      end
      cdq_pkg::S_LRD: begin
        // read only once the output slot will be empty when the word lands
        if (out_free_i) begin
          re_o    = 1'b1;
          raddr_o = ptr_q;
          state_d = cdq_pkg::S_LDAT;
        end
      end
      cdq_pkg::S_LDAT: begin
        res_o.load     = 1'b1;
        res_o.status   = cdq_pkg::ST_OK;
        res_o.from_mem = 1'b1;
        res_o.last     = list_last;
        ptr_d          = cdq_pkg::next_idx(ptr_q);
        n_d            = cdq_pkg::CNT_W'(n_q + 1'b1);
        state_d        = list_last ? cdq_pkg::S_IDLE : cdq_pkg::S_LRD;
      end
      default: begin
        state_d = cdq_pkg::S_IDLE;
      end
    endcase
  end

  `CDQ_ASSERT_IMP(a_occ_bound, 1'b1, occ_q <= cdq_pkg::DEPTH_C, "occupancy above depth")
  `CDQ_ASSERT_IMP(a_empty_idx, occ_q == '0, (head_q == '0) && (tail_q == '0), "empty, indices not zero")
  `CDQ_ASSERT_IMP(a_load_free, res_o.load, out_free_i, "result loaded into busy output slot")
  `CDQ_ASSERT_NXT(a_read_then_load, re_o, res_o.load && res_o.from_mem, "read data not taken")
  `CDQ_ASSERT_IMP(a_no_rw_overlap, we_o, !re_o, "memory read and write in one cycle")

endmodule

// ===== hdl/circular_double_ended_queue.sv =====
// Top level of the circular deque: controller, entry RAM and output register.
//
// A deque of DEPTH signed 32-bit words held in a synchronous RAM. A push
// is handled in the idle state and its result sits in the output register
// on the next edge. A pop first reads the RAM, then lands the word. A list
// request blocks input while it walks the stored words, reading each from
// the RAM and then landing it, and while the output side stalls, because
// each RAM read is issued only when the output register will be free. A new
// request is taken only while the controller is idle and the output register
// is empty or being drained. Unknown commands are consumed with no result.
// The RAM needs no clearing after reset: only written entries are ever read.
module circular_double_ended_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [2:0]                 command_i,
  input  logic signed [31:0]         push_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic signed [31:0]         data_word_o,
  output logic                       last_result_o
);

  cdq_pkg::res_t               res;
  logic                        out_free;
  logic                        we;
  logic [cdq_pkg::IDX_W-1:0]   waddr;
  logic [cdq_pkg::DATA_W-1:0]  wdata;
  logic                        re;
  logic [cdq_pkg::IDX_W-1:0]   raddr;
  logic [cdq_pkg::DATA_W-1:0]  rdata;

  logic                        out_valid_q;
  logic [1:0]                  status_q;
  logic [cdq_pkg::DATA_W-1:0]  data_q;
  logic                        last_q;

  assign out_free = !out_valid_q || out_ready_i;

  cdq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .push_value_i (push_value_i),
    .out_free_i   (out_free),
    .res_o        (res),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .re_o         (re),
    .raddr_o      (raddr)
  );

  cdq_ram #(
    .DataWidth (cdq_pkg::DATA_W),
    .Depth     (cdq_pkg::DEPTH),
    .AddrWidth (cdq_pkg::IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      status_q <= res.status;
      data_q   <= res.from_mem ? rdata : '0;
      last_q   <= res.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign data_word_o   = data_q;
  assign last_result_o = last_q;

endmodule
